FILE: hdl/kvap_pkg.sv
// shared types and constants of the key:value argument parser
package kvap_pkg;

    // character codes
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // default depth of the queue between front and back
    localparam int KVAP_QUEUE_DEPTH = 4;

    // parse outcome codes
    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_KEY,
        ST_BAD_ESC,
        ST_OPEN_QUOTE
    } t_status;

    // classified input byte as it travels through the queue
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_blank;
        logic       is_colon;
        logic       is_quote;
        logic       is_bsl;
    } t_item;

    // one result request
    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       byte_is_key;
        logic       key_end;
        logic       pair_end;
        logic       finished;
        t_status    status;
    } t_result;

endpackage

FILE: hdl/kvap_front.sv
// front stage: accepts input bytes and classifies each character
module kvap_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [7:0]    i_s_tdata,   // data_byte[7:0]
    input  logic          i_s_tlast,   // last_byte
    input  logic          i_q_full,
    output logic          o_push,
    output kvap_pkg::t_item o_item
);
    import kvap_pkg::*;

    logic r_ready_en;

    // hold off requests during reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_en <= 1'b0;
        end else begin
            r_ready_en <= 1'b1;
        end
    end

    // accept whenever the queue has room, once out of reset
    assign o_s_tready = r_ready_en && !i_q_full;
    assign o_push     = i_s_tvalid && o_s_tready;

    // character classification
    always_comb begin
        o_item.data     = i_s_tdata;
        o_item.last     = i_s_tlast;
        o_item.is_blank = (i_s_tdata == CH_SPACE) || (i_s_tdata == CH_TAB);
        o_item.is_colon = (i_s_tdata == CH_COLON);
        o_item.is_quote = (i_s_tdata == CH_QUOTE);
        o_item.is_bsl   = (i_s_tdata == CH_BSL);
    end

endmodule

FILE: hdl/kvap_queue.sv
// short queue of classified bytes between front and back
module kvap_queue #(
    parameter int DEPTH = kvap_pkg::KVAP_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  kvap_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output kvap_pkg::t_item o_item
);
    import kvap_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr_ptr;
    logic [AW-1:0]  n_rd_ptr;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // pointer wrap
    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
    assign n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: hdl/kvap_back.sv
// back stage: parse state machine and output register
module kvap_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  kvap_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output kvap_pkg::t_result o_result
);
    import kvap_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_GAP,
        PH_KEY,
        PH_VAL,
        PH_ESC,
        PH_ERR_KEY,
        PH_ERR_ESC,
        PH_ERR_QUO
    } t_phase;

    t_phase  r_phase;
    logic    r_quotes;
    logic    r_out_valid;
    t_result r_out;

    t_phase  n_phase;
    logic    n_quotes;
    logic    n_emit;
    t_result n_res;
    logic    w_nq;

    // pop when the output register is free or being drained
    assign o_pop      = i_q_valid && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_result   = r_out;
    assign w_nq       = !r_quotes;

    // next state and result of one byte
    always_comb begin
        n_phase  = r_phase;
        n_quotes = r_quotes;
        n_emit   = 1'b0;
        n_res    = '0;
        n_res.status = ST_OK;
        case (r_phase)
            PH_LEAD, PH_GAP: begin
                if (i_item.is_blank) begin
                    if (i_item.last) begin
                        n_emit         = 1'b1;
                        n_res.finished = 1'b1;
                        n_res.status   = (r_phase == PH_GAP) ? ST_OK : ST_BAD_KEY;
                    end
                end else if (i_item.is_colon || i_item.last) begin
                    if (i_item.last) begin
                        n_emit         = 1'b1;
                        n_res.finished = 1'b1;
                        n_res.status   = ST_BAD_KEY;
                    end else begin
                        n_phase = PH_ERR_KEY;
                    end
                end else begin
                    n_phase           = PH_KEY;
                    n_emit            = 1'b1;
                    n_res.has_byte    = 1'b1;
                    n_res.out_byte    = i_item.data;
                    n_res.byte_is_key = 1'b1;
                end
            end
            PH_KEY: begin
                if (i_item.is_colon) begin
                    n_quotes      = 1'b0;
                    n_phase       = PH_VAL;
                    n_emit        = 1'b1;
                    n_res.key_end = 1'b1;
                    if (i_item.last) begin
                        n_res.pair_end = 1'b1;
                        n_res.finished = 1'b1;
                    end
                end else if (i_item.last) begin
                    n_emit         = 1'b1;
                    n_res.finished = 1'b1;
                    n_res.status   = ST_BAD_KEY;
                end else begin
                    n_emit            = 1'b1;
                    n_res.has_byte    = 1'b1;
                    n_res.out_byte    = i_item.data;
                    n_res.byte_is_key = 1'b1;
                end
            end
            PH_VAL: begin
                if (i_item.is_bsl) begin
                    if (i_item.last) begin
                        n_emit         = 1'b1;
                        n_res.finished = 1'b1;
                        n_res.status   = ST_BAD_ESC;
                    end else begin
                        n_phase = PH_ESC;
                    end
                end else if (i_item.is_quote) begin
                    n_quotes = w_nq;
                    if (i_item.last) begin
                        n_emit         = 1'b1;
                        n_res.finished = 1'b1;
                        if (w_nq) begin
                            n_res.status = ST_OPEN_QUOTE;
                        end else begin
                            n_res.pair_end = 1'b1;
                        end
                    end
                end else if (i_item.is_blank && !r_quotes) begin
                    n_phase        = PH_GAP;
                    n_emit         = 1'b1;
                    n_res.pair_end = 1'b1;
                    n_res.finished = i_item.last;
                end else if (i_item.last) begin
                    n_emit         = 1'b1;
                    n_res.finished = 1'b1;
                    if (r_quotes) begin
                        n_res.status = ST_OPEN_QUOTE;
                    end else begin
                        n_res.has_byte = 1'b1;
                        n_res.out_byte = i_item.data;
                        n_res.pair_end = 1'b1;
                    end
                end else begin
                    n_emit         = 1'b1;
                    n_res.has_byte = 1'b1;
                    n_res.out_byte = i_item.data;
                end
            end
            PH_ESC: begin
                if (!i_item.is_quote && !i_item.is_bsl) begin
                    if (i_item.last) begin
                        n_emit         = 1'b1;
                        n_res.finished = 1'b1;
                        n_res.status   = ST_BAD_ESC;
                    end else begin
                        n_phase = PH_ERR_ESC;
                    end
                end else begin
                    n_phase = PH_VAL;
                    n_emit  = 1'b1;
                    if (i_item.last) begin
                        n_res.finished = 1'b1;
                        if (r_quotes) begin
                            n_res.status = ST_OPEN_QUOTE;
                        end else begin
                            n_res.has_byte = 1'b1;
                            n_res.out_byte = i_item.data;
                            n_res.pair_end = 1'b1;
                        end
                    end else begin
                        n_res.has_byte = 1'b1;
                        n_res.out_byte = i_item.data;
                    end
                end
            end
            PH_ERR_KEY: begin
                if (i_item.last) begin
                    n_emit         = 1'b1;
                    n_res.finished = 1'b1;
                    n_res.status   = ST_BAD_KEY;
                end
            end
            PH_ERR_ESC: begin
                if (i_item.last) begin
                    n_emit         = 1'b1;
                    n_res.finished = 1'b1;
                    n_res.status   = ST_BAD_ESC;
                end
            end
            default: begin
                if (i_item.last) begin
                    n_emit         = 1'b1;
                    n_res.finished = 1'b1;
                    n_res.status   = ST_OPEN_QUOTE;
                end
            end
        endcase
        // outcome reported: back to the start of a string
        if (n_res.finished) begin
            n_phase  = PH_LEAD;
            n_quotes = 1'b0;
        end
    end

    // parse state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_quotes    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase  <= n_phase;
                r_quotes <= n_quotes;
            end
            if (o_pop && n_emit) begin
                r_out_valid <= 1'b1;
                r_out       <= n_res;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // every string end leaves the parser at its start state
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.last |=> (r_phase == PH_LEAD) && !r_quotes)
        else $error("parser not back at start after last byte");

    // a string end always produces an outcome request
    a_last_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.last |=> r_out_valid && r_out.finished)
        else $error("last byte gave no outcome");

    // no byte field without a byte
    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.has_byte |-> !r_out.byte_is_key && (r_out.out_byte == '0))
        else $error("byte fields set without a byte");

    // status only with an outcome
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.finished |-> (r_out.status == ST_OK))
        else $error("status set without finished");

endmodule

FILE: hdl/key_value_arg_parser_unit.sv
// top level of the key:value argument parser
//
//  channel | dir | tdata                  | tlast     | tuser
//  s       | in  | data_byte              | last_byte | -
//  m       | out | has_byte..status       | finished  | byte_is_key
//
// one byte is accepted every clock cycle while the queue has room; the parse state
// machine in the back stage handles one byte per cycle unless the output stalls,
// so the rate is one byte per cycle; a byte is queued, then its result registered.
// reset (synchronous, active low) clears the parse state, the queue and the
// output register. a stalled output is absorbed by the QUEUE_DEPTH-entry
// queue; input ready is low in reset and in the first cycle after it, and
// otherwise drops only when that queue is full.
module key_value_arg_parser_unit #(
    parameter int QUEUE_DEPTH = kvap_pkg::KVAP_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [0] has_byte, [8:1] out_byte, [9] key_end,
                                     // [10] pair_end, [12:11] status, [15:13] zero
    output logic        o_m_tlast,   // finished
    output logic        o_m_tuser    // byte_is_key
);
    import kvap_pkg::*;

    logic    w_push;
    t_item   w_push_item;
    logic    w_q_full;
    logic    w_q_valid;
    t_item   w_q_item;
    logic    w_pop;
    t_result w_res;

    // accept and classify
    kvap_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    // decoupling queue
    kvap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // parse and emit
    kvap_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_item     (w_q_item),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_result   (w_res)
    );

    // output packing
    assign o_m_tdata = {3'b000, w_res.status, w_res.pair_end, w_res.key_end,
                        w_res.out_byte, w_res.has_byte};
    assign o_m_tlast = w_res.finished;
    assign o_m_tuser = w_res.byte_is_key;

endmodule
